// ===== rtl/led128_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led128_pkg
// Shared types, constants and round functions of the LED-style block cipher.
// ----------------------------------------------------------------------------
package led128_pkg;

  typedef logic [63:0] block_t;
  typedef logic [3:0]  nib_t;
  typedef logic [5:0]  rc_t;

  // 4-bit substitution box
  localparam nib_t SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // key-size constants xored into column 0, rows 0 to 3
  localparam nib_t KS_ROW0 = 4'h8;
  localparam nib_t KS_ROW1 = 4'h9;
  localparam nib_t KS_ROW2 = 4'h2;
  localparam nib_t KS_ROW3 = 4'h3;

  // rounds per step
  localparam int ROUNDS_PER_STEP = 4;

  // round constant after n+1 advances of the lfsr, starting from zero
  function automatic rc_t rc_at(input int n);
    rc_t rc;
    rc = '0;
    for (int i = 0; i <= n; i++) begin
      rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
    end
    return rc;
  endfunction

  // multiply by x in GF(16), x^4+x+1
  function automatic nib_t gf_dbl(input nib_t a);
    return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
  endfunction

  // in-place column mix, later rows use rows already updated
  function automatic logic [15:0] mix_col(input logic [15:0] col);
    nib_t a0, a1, a2, a3;
    a0 = col[3:0];
    a1 = col[7:4];
    a2 = col[11:8];
    a3 = col[15:12];
    a0 = gf_dbl(gf_dbl(a0)) ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3);
    a1 = gf_dbl(gf_dbl(a1)) ^ a2 ^ gf_dbl(a3) ^ gf_dbl(a0);
    a2 = gf_dbl(gf_dbl(a2)) ^ a3 ^ gf_dbl(a0) ^ gf_dbl(a1);
    a3 = gf_dbl(gf_dbl(a3)) ^ a0 ^ gf_dbl(a1) ^ gf_dbl(a2);
    return {a3, a2, a1, a0};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/led128_round_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led128_round_cell
// One cipher round as a pipeline cell: optional key add, constants, S-box,
// row shift and column mix, registered with its valid bit.
// ----------------------------------------------------------------------------
module led128_round_cell
  import led128_pkg::*;
#(
  parameter bit        ADD_KEY = 1'b0,
  parameter logic [5:0] RC     = 6'h01
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         en,
  input  wire         in_valid,
  input  wire block_t in_data,
  input  wire block_t key,
  output logic        out_valid,
  output block_t      out_data
);

  block_t keyed;
  nib_t   st  [16];
  nib_t   sub [16];
  block_t round_out;

  // key add at the start of a step
  assign keyed = ADD_KEY ? (in_data ^ key) : in_data;

  // add constants, substitute and shift rows
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      st[k] = keyed[4*k +: 4];
    end
    st[0]  = st[0]  ^ KS_ROW0;
    st[4]  = st[4]  ^ KS_ROW1;
    st[8]  = st[8]  ^ KS_ROW2;
    st[12] = st[12] ^ KS_ROW3;
    st[1]  = st[1]  ^ {1'b0, RC[5:3]};
    st[9]  = st[9]  ^ {1'b0, RC[5:3]};
    st[5]  = st[5]  ^ {1'b0, RC[2:0]};
    st[13] = st[13] ^ {1'b0, RC[2:0]};
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sub[4*r + c] = SBOX[st[4*r + ((c + r) % 4)]];
      end
    end
  end

  // column mix
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      {round_out[4*(12+c) +: 4], round_out[4*(8+c) +: 4],
       round_out[4*(4+c) +: 4], round_out[4*c +: 4]} =
        mix_col({sub[12+c], sub[8+c], sub[4+c], sub[c]});
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= round_out;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/led128_block_encrypt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led128_block_encrypt
// LED-style 64-bit block encryption under a 128-bit key held in two registers.
// ----------------------------------------------------------------------------
// Fully unrolled round pipeline: a row of 4*STEP_COUNT round cells, one round
// per cell, so a word enters every cycle while the chain advances and moves
// through each cell's register in turn. The cell chain advances as a whole when
// the output word is taken or the output slot is empty; the last cell's
// register is the output register and the final key add sits on its output.
// Keys are written over the APB port at byte address 0 (key_low) and 8
// (key_high), by the user only while no word is in flight; not enforced here.
module led128_block_encrypt
  import led128_pkg::*;
#(
  parameter int STEP_COUNT = 12
) (
  input  wire         clk,
  input  wire         rst,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // [63:0] plain_block
  // output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [63:0] cipher_block
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int ROUNDS = ROUNDS_PER_STEP * STEP_COUNT;

  block_t key_low;
  block_t key_high;
  logic   advance;
  logic   vld  [ROUNDS+1];
  block_t data [ROUNDS+1];

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        key_high <= pwdata;
      end else begin
        key_low <= pwdata;
      end
    end
  end

  assign prdata = paddr[3] ? key_high : key_low;

  // chain moves when the output word is free or taken, no input during reset
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rst && advance;

  assign vld[0]  = s_tvalid;
  assign data[0] = s_tdata;

  // round cells
  for (genvar j = 0; j < ROUNDS; j++) begin : g_cell
    localparam bit   FIRST = ((j % ROUNDS_PER_STEP) == 0);
    localparam bit   ODD   = (((j / ROUNDS_PER_STEP) % 2) == 1);
    localparam rc_t  RCJ   = rc_at(j);
    led128_round_cell #(
      .ADD_KEY (FIRST),
      .RC      (RCJ)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (vld[j]),
      .in_data   (data[j]),
      .key       (ODD ? key_high : key_low),
      .out_valid (vld[j+1]),
      .out_data  (data[j+1])
    );
  end

  // final key add on the output register
  assign m_tvalid = vld[ROUNDS];
  assign m_tdata  = data[ROUNDS] ^ (((STEP_COUNT % 2) == 1) ? key_high : key_low);

  // a waiting output word holds the whole chain
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output word waits");

  // an accepted word occupies the first cell
  a_accept_fills_cell: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted word lost at first cell");

  // key write lands in the addressed register
  a_key_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[3]) |=> (key_low == $past(pwdata)))
    else $error("key_low write not taken");

  a_key_write_hi: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[3]) |=> (key_high == $past(pwdata)))
    else $error("key_high write not taken");

endmodule
`default_nettype wire
